### hw/rtl/vpt_pkg.sv
// shared types, constants and tables of the vax page table walker
package vpt_pkg;

    localparam int QDEPTH = 4;

    localparam logic [31:0] BASE_MASK = 32'hFFFF_FFFC;
    localparam logic [31:0] E_MODIFY  = 32'h0400_0000;

    localparam logic [2:0] REG_P0_BASE    = 3'd0;
    localparam logic [2:0] REG_P0_LENGTH  = 3'd1;
    localparam logic [2:0] REG_P1_BASE    = 3'd2;
    localparam logic [2:0] REG_P1_LENGTH  = 3'd3;
    localparam logic [2:0] REG_SYS_BASE   = 3'd4;
    localparam logic [2:0] REG_SYS_LENGTH = 3'd5;
    localparam logic [2:0] REG_MAP_ENABLE = 3'd6;

    localparam logic [7:0] PROT_TABLE [16] = '{
        8'h00, 8'h00, 8'h11, 8'h01, 8'hFF, 8'h33, 8'h13, 8'h03,
        8'h77, 8'h37, 8'h17, 8'h07, 8'h7F, 8'h3F, 8'h1F, 8'h0F
    };

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_OK  = 2'd0,
        FAULT_ACV = 2'd1,
        FAULT_TNV = 2'd2,
        FAULT_LNV = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_SYS  = 2'd1,
        PHASE_PTE  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_DONE       = 2'd1,
        ACT_ASK        = 2'd2,
        ACT_WRITE_DONE = 2'd3
    } act_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] vaddr;
        logic        is_write;
        logic [1:0]  access_mode;
        logic [31:0] read_data;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [29:0] phys_addr;
        fault_t      fault;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        two;
        kind_t       kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [29:0] phys_addr;
        fault_t      fault;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

### hw/rtl/vpt_queue.sv
// small job queue between the classifying front and the result back end
module vpt_queue
    import vpt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/vpt_front.sv
// front end: configuration registers, walk state and classification of each transaction
module vpt_front
    import vpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        accept,
    input  in_item_t    item,
    output logic        job_valid,
    output job_t        job
);

    logic [31:0] p0_base_reg, p1_base_reg, sys_base_reg;
    logic [21:0] p0_length_reg, p1_length_reg, sys_length_reg;
    logic        map_enable_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] held_vaddr_reg, held_vaddr_next;
    logic        held_write_reg, held_write_next;
    logic [1:0]  held_am_reg, held_am_next;
    logic [31:0] pending_reg, pending_next;

    logic [20:0] va_vpn;
    logic [31:0] eva, sys_addr_eva, sys_addr_va, frame_addr, entry;
    logic [21:0] eva_vpn;
    logic        seg_lnv, s0_lnv, eva_lnv, allowed;
    logic [7:0]  prot;
    logic [2:0]  need_idx;
    logic [29:0] pa_entry;

    act_t        act;
    phase_t      ask_phase;
    logic [31:0] ask_addr, ask_pend;
    fault_t      fin_fault;
    logic [29:0] fin_pa;

    // address arithmetic and checks
    always_comb
    begin
        va_vpn       = item.vaddr[29:9];
        seg_lnv      = item.vaddr[30] ? ({1'b0, va_vpn} < p1_length_reg)
                                      : ({1'b0, va_vpn} >= p0_length_reg);
        s0_lnv       = {1'b0, va_vpn} >= sys_length_reg;
        eva          = (item.vaddr[30] ? p1_base_reg : p0_base_reg) + {9'b0, va_vpn, 2'b00};
        eva_vpn      = eva[30:9];
        eva_lnv      = eva_vpn >= sys_length_reg;
        sys_addr_eva = sys_base_reg + {8'b0, eva_vpn, 2'b00};
        sys_addr_va  = sys_base_reg + {9'b0, va_vpn, 2'b00};
        entry        = item.read_data;
        prot         = PROT_TABLE[entry[30:27]];
        need_idx     = (phase_reg == PHASE_PTE) ? {held_write_reg, held_am_reg} : 3'd0;
        allowed      = prot[need_idx];
        frame_addr   = {2'b00, entry[20:0], pending_reg[8:0]};
        pa_entry     = {entry[20:0], held_vaddr_reg[8:0]};
    end

    // classification
    always_comb
    begin
        act       = ACT_NONE;
        ask_phase = PHASE_PTE;
        ask_addr  = eva;
        ask_pend  = eva;
        fin_fault = FAULT_OK;
        fin_pa    = '0;
        if (!item.mode)
        begin
            if (!map_enable_reg)
            begin
                act    = ACT_DONE;
                fin_pa = item.vaddr[29:0];
            end
            else
            begin
                case (item.vaddr[31:30])
                    2'b00, 2'b01:
                    begin
                        if (seg_lnv || (eva[31] && eva_lnv))
                        begin
                            act       = ACT_DONE;
                            fin_fault = FAULT_LNV;
                        end
                        else if (!eva[31])
                        begin
                            act = ACT_ASK;
                        end
                        else
                        begin
                            act       = ACT_ASK;
                            ask_phase = PHASE_SYS;
                            ask_addr  = sys_addr_eva;
                        end
                    end
                    2'b10:
                    begin
                        if (s0_lnv)
                        begin
                            act       = ACT_DONE;
                            fin_fault = FAULT_LNV;
                        end
                        else
                        begin
                            act      = ACT_ASK;
                            ask_addr = sys_addr_va;
                            ask_pend = sys_addr_va;
                        end
                    end
                    default:
                    begin
                        act       = ACT_DONE;
                        fin_fault = FAULT_LNV;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PHASE_SYS, PHASE_PTE:
                begin
                    if (!allowed)
                    begin
                        act       = ACT_DONE;
                        fin_fault = FAULT_ACV;
                    end
                    else if (!entry[31])
                    begin
                        act       = ACT_DONE;
                        fin_fault = FAULT_TNV;
                    end
                    else if (phase_reg == PHASE_SYS)
                    begin
                        act      = ACT_ASK;
                        ask_addr = frame_addr;
                        ask_pend = frame_addr;
                    end
                    else
                    begin
                        fin_pa = pa_entry;
                        act    = (held_write_reg && !entry[26]) ? ACT_WRITE_DONE : ACT_DONE;
                    end
                end
                default:
                begin
                    act = ACT_NONE;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        held_vaddr_next = held_vaddr_reg;
        held_write_next = held_write_reg;
        held_am_next    = held_am_reg;
        pending_next    = pending_reg;
        if (accept)
        begin
            if (!item.mode)
            begin
                held_vaddr_next = item.vaddr;
                held_write_next = item.is_write;
                held_am_next    = item.access_mode;
            end
            case (act)
                ACT_ASK:
                begin
                    phase_next   = ask_phase;
                    pending_next = ask_pend;
                end
                ACT_DONE, ACT_WRITE_DONE:
                begin
                    phase_next = PHASE_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // job for the back end
    always_comb
    begin
        job_valid     = (act != ACT_NONE);
        job.two       = (act == ACT_WRITE_DONE);
        job.kind      = (act == ACT_ASK) ? KIND_READ : KIND_DONE;
        job.mem_addr  = '0;
        job.mem_wdata = '0;
        job.phys_addr = (act == ACT_ASK) ? '0 : fin_pa;
        job.fault     = (act == ACT_ASK) ? FAULT_OK : fin_fault;
        case (act)
            ACT_ASK:
            begin
                job.mem_addr = ask_addr;
            end
            ACT_WRITE_DONE:
            begin
                job.mem_addr  = pending_reg;
                job.mem_wdata = entry | E_MODIFY;
            end
            default:
            begin
                job.mem_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_base_reg    <= '0;
            p0_length_reg  <= '0;
            p1_base_reg    <= '0;
            p1_length_reg  <= '0;
            sys_base_reg   <= '0;
            sys_length_reg <= '0;
            map_enable_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_P0_BASE:    p0_base_reg    <= cfg_wdata & BASE_MASK;
                REG_P0_LENGTH:  p0_length_reg  <= cfg_wdata[21:0];
                REG_P1_BASE:    p1_base_reg    <= cfg_wdata & BASE_MASK;
                REG_P1_LENGTH:  p1_length_reg  <= cfg_wdata[21:0];
                REG_SYS_BASE:   sys_base_reg   <= cfg_wdata & BASE_MASK;
                REG_SYS_LENGTH: sys_length_reg <= cfg_wdata[21:0];
                REG_MAP_ENABLE: map_enable_reg <= cfg_wdata[0];
                default:        map_enable_reg <= map_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_IDLE;
            held_vaddr_reg <= '0;
            held_write_reg <= 1'b0;
            held_am_reg    <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_vaddr_reg <= held_vaddr_next;
            held_write_reg <= held_write_next;
            held_am_reg    <= held_am_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

### hw/rtl/vpt_back.sv
// back end: expands queued jobs into result transactions through an output register
module vpt_back
    import vpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      second_reg, second_next;
    logic      load;

    assign load      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        second_next    = second_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            out_valid_next = q_status.valid;
            if (q_status.valid)
            begin
                if (q_job.two && !second_reg)
                begin
                    // modify bit write back goes out ahead of the done
                    out_data_next.kind      = KIND_WRITE;
                    out_data_next.mem_addr  = q_job.mem_addr;
                    out_data_next.mem_wdata = q_job.mem_wdata;
                    out_data_next.phys_addr = '0;
                    out_data_next.fault     = FAULT_OK;
                    out_data_next.last      = 1'b0;
                    second_next             = 1'b1;
                end
                else
                begin
                    out_data_next.kind      = q_job.two ? KIND_DONE : q_job.kind;
                    out_data_next.mem_addr  = q_job.two ? '0 : q_job.mem_addr;
                    out_data_next.mem_wdata = '0;
                    out_data_next.phys_addr = q_job.phys_addr;
                    out_data_next.fault     = q_job.fault;
                    out_data_next.last      = 1'b1;
                    second_next             = 1'b0;
                    q_pop                   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### hw/rtl/vax_page_table_walker.sv
// top level of the vax page table walker
// an accepted transaction's job is written into the job queue, then loaded into the output
// register, where out_ready takes it; queued jobs ahead and output stalls can delay it
// throughput: one input transaction per cycle; a write back plus done gives two results
// the front stalls only when the job queue is full; the output register decouples out_ready
// reset (async, active low) empties the queue and zeroes walk state, config regs and out_valid
module vax_page_table_walker
    import vpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QDEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    localparam int JOB_W = $bits(job_t);

    logic       accept;
    logic       job_valid;
    job_t       front_job;
    job_t       q_job;
    logic [JOB_W-1:0] q_data;
    q_status_t  q_status;
    logic       q_pop;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign q_job    = job_t'(q_data);

    vpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (in_data),
        .job_valid (job_valid),
        .job       (front_job)
    );

    vpt_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && job_valid),
        .push_data (front_job),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    vpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_WRITE) |-> !out_data.last)
        else $error("write back marked as last result");

    a_fault_no_pa: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_DONE && out_data.fault != FAULT_OK)
            |-> (out_data.phys_addr == '0))
        else $error("faulted translation carries an address");

    a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.kind == KIND_WRITE)
            |=> (out_valid && out_data.kind == KIND_DONE && out_data.last))
        else $error("write back not followed by its done");

endmodule

### tb/sv/tb_vax_page_table_walker.sv
// testbench for the vax page table walker: translation scoreboard and top-level stimulus
import vpt_pkg::*;

class walk_scoreboard;
    logic [31:0] p0_base, p0_length, p1_base, p1_length, sys_base, sys_length;
    logic        map_on;
    phase_t      phase;
    logic [31:0] held_va;
    logic        held_wr;
    logic [1:0]  held_am;
    logic [31:0] pend_addr;
    logic [7:0]  access_bits [16];
    out_item_t   expected_results [$];
    int          errors;

    function new();
        access_bits = '{8'h00, 8'h00, 8'h11, 8'h01, 8'hFF, 8'h33, 8'h13, 8'h03,
                        8'h77, 8'h37, 8'h17, 8'h07, 8'h7F, 8'h3F, 8'h1F, 8'h0F};
        p0_base = '0;
        p0_length = '0;
        p1_base = '0;
        p1_length = '0;
        sys_base = '0;
        sys_length = '0;
        map_on = 1'b0;
        phase = PHASE_IDLE;
        held_va = '0;
        held_wr = 1'b0;
        held_am = '0;
        pend_addr = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_P0_BASE:    p0_base = v & BASE_MASK;
            REG_P0_LENGTH:  p0_length = {10'd0, v[21:0]};
            REG_P1_BASE:    p1_base = v & BASE_MASK;
            REG_P1_LENGTH:  p1_length = {10'd0, v[21:0]};
            REG_SYS_BASE:   sys_base = v & BASE_MASK;
            REG_SYS_LENGTH: sys_length = {10'd0, v[21:0]};
            REG_MAP_ENABLE: map_on = v[0];
            default: ;
        endcase
    endfunction

    function void push(kind_t k, logic [31:0] a, logic [31:0] wd, logic [29:0] pa,
                       fault_t f, logic last);
        out_item_t r;
        r.kind = k;
        r.mem_addr = a;
        r.mem_wdata = wd;
        r.phys_addr = pa;
        r.fault = f;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function void finish_walk(logic [29:0] pa, fault_t f);
        phase = PHASE_IDLE;
        push(KIND_DONE, '0, '0, (f == FAULT_OK) ? pa : 30'd0, f, 1'b1);
    endfunction

    function void fetch_entry(phase_t p, logic [31:0] a);
        phase = p;
        pend_addr = a;
        push(KIND_READ, a, '0, '0, FAULT_OK, 1'b1);
    endfunction

    function bit permits(logic [31:0] e, logic wr, logic [1:0] am);
        logic [7:0] need;
        need = 8'd1 << am;
        if (wr)
            need = need << 4;
        return (access_bits[e[30:27]] & need) != 8'd0;
    endfunction

    // process table entry: physical, or located through the system table first
    function void locate_process_entry(logic [31:0] eva);
        logic [31:0] vpn;
        if (!eva[31])
            fetch_entry(PHASE_PTE, eva);
        else
        begin
            vpn = (eva - 32'h8000_0000) >> 9;
            if (vpn >= sys_length)
                finish_walk('0, FAULT_LNV);
            else
            begin
                phase = PHASE_SYS;
                pend_addr = eva;
                push(KIND_READ, sys_base + (vpn << 2), '0, '0, FAULT_OK, 1'b1);
            end
        end
    endfunction

    function void translate(in_item_t it);
        logic [31:0] va, idx;
        va = it.vaddr;
        held_va = va;
        held_wr = it.is_write;
        held_am = it.access_mode;
        phase = PHASE_IDLE;
        if (!map_on)
            finish_walk(va[29:0], FAULT_OK);
        else if (va < 32'h4000_0000)
        begin
            idx = va >> 9;
            if (idx >= p0_length)
                finish_walk('0, FAULT_LNV);
            else
                locate_process_entry(p0_base + (idx << 2));
        end
        else if (va < 32'h8000_0000)
        begin
            idx = (va - 32'h4000_0000) >> 9;
            if (idx < p1_length)
                finish_walk('0, FAULT_LNV);
            else
                locate_process_entry(p1_base + (idx << 2));
        end
        else if (va < 32'hC000_0000)
        begin
            idx = (va - 32'h8000_0000) >> 9;
            if (idx >= sys_length)
                finish_walk('0, FAULT_LNV);
            else
                fetch_entry(PHASE_PTE, sys_base + (idx << 2));
        end
        else
            finish_walk('0, FAULT_LNV);
    endfunction

    function void take_entry(logic [31:0] e);
        logic [29:0] pa;
        case (phase)
            PHASE_SYS:
            begin
                if (!permits(e, 1'b0, 2'd0))
                    finish_walk('0, FAULT_ACV);
                else if (!e[31])
                    finish_walk('0, FAULT_TNV);
                else
                    fetch_entry(PHASE_PTE, {2'b00, e[20:0], pend_addr[8:0]});
            end
            PHASE_PTE:
            begin
                if (!permits(e, held_wr, held_am))
                    finish_walk('0, FAULT_ACV);
                else if (!e[31])
                    finish_walk('0, FAULT_TNV);
                else
                begin
                    pa = {e[20:0], held_va[8:0]};
                    phase = PHASE_IDLE;
                    if (held_wr && !e[26])
                    begin
                        push(KIND_WRITE, pend_addr, e | E_MODIFY, '0, FAULT_OK, 1'b0);
                        push(KIND_DONE, '0, '0, pa, FAULT_OK, 1'b1);
                    end
                    else
                        finish_walk(pa, FAULT_OK);
                end
            end
            default: ;
        endcase
    endfunction

    function void note_input(in_item_t it);
        if (!it.mode)
            translate(it);
        else
            take_entry(it.read_data);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("result transaction with none expected, kind %0d", got.kind);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare("kind", want.kind, got.kind);
        compare("mem_addr", want.mem_addr, got.mem_addr);
        compare("mem_wdata", want.mem_wdata, got.mem_wdata);
        compare("phys_addr", want.phys_addr, got.phys_addr);
        compare("fault", want.fault, got.fault);
        compare("last", want.last, got.last);
    endfunction
endclass

module tb_vax_page_table_walker;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = REG_P0_BASE;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    walk_scoreboard sb = new();
    int gap_max = 0;
    int stall_mode = 0;
    int burst_left = 0;
    bit hold_request = 1'b0;

    vax_page_table_walker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_vax_page_table_walker: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // result side: always ready, runs of stalls, or one long hold-off
    initial
    begin : receiver
        bit level;
        int run_left;
        level = 1'b1;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (stall_mode == 0)
                out_ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    level = !level;
                    run_left = level ? $urandom_range(1, 8)
                                     : $urandom_range(1, (stall_mode == 1) ? 2 : 6);
                end
                out_ready <= level;
                run_left--;
            end
        end
    end

    task automatic pace();
        int n;
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                n = $urandom_range(1, gap_max);
                repeat (n)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge clk);
    endtask

    task automatic present(in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send(in_item_t it);
        pace();
        present(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
    endtask

    function automatic in_item_t request(logic [31:0] va, logic wr, logic [1:0] am);
        in_item_t it;
        it = '0;
        it.vaddr = va;
        it.is_write = wr;
        it.access_mode = am;
        return it;
    endfunction

    function automatic in_item_t entry(logic [31:0] e);
        in_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.read_data = e;
        return it;
    endfunction

    function automatic logic [31:0] pte(logic v, logic [3:0] prot, logic m, logic [20:0] pfn);
        return {v, prot, m, 5'd0, pfn};
    endfunction

    function automatic logic [31:0] rand_base();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 32'h0003_FFFF);
            1: return 32'h8000_0000 + $urandom_range(0, 32'h3FFF);
            2: return 32'hC000_0000 | $urandom;
            3: return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 3))
            0: return ($urandom & 32'hFFC0_0000) | $urandom_range(0, 3);
            1: return ($urandom & 32'hFFC0_0000) | $urandom_range(4, 48);
            2: return $urandom;
            default: return $urandom | 32'h003F_FFFF;
        endcase
    endfunction

    task automatic configure(int which);
        logic [31:0] fill;
        if (which < 2)
        begin
            fill = (which == 0) ? 32'h0000_0003 : 32'hFFFF_FFFF;
            write_reg(REG_P0_BASE, fill);
            write_reg(REG_P0_LENGTH, (which == 0) ? 32'hFFC0_0000 : fill);
            write_reg(REG_P1_BASE, fill);
            write_reg(REG_P1_LENGTH, (which == 0) ? 32'hFFC0_0000 : fill);
            write_reg(REG_SYS_BASE, fill);
            write_reg(REG_SYS_LENGTH, (which == 0) ? 32'hFFC0_0000 : fill);
            write_reg(REG_MAP_ENABLE, 32'hFFFF_FFFF);
        end
        else
        begin
            write_reg(REG_P0_BASE, rand_base());
            write_reg(REG_P0_LENGTH, rand_length());
            write_reg(REG_P1_BASE, rand_base());
            write_reg(REG_P1_LENGTH, rand_length());
            write_reg(REG_SYS_BASE, rand_base());
            write_reg(REG_SYS_LENGTH, rand_length());
            write_reg(REG_MAP_ENABLE, ($urandom & 32'hFFFF_FFFE) |
                      ((which != 2 && $urandom_range(0, 5) != 0) ? 32'd1 : 32'd0));
        end
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // page index near the region length, mostly on the requested side of it
    function automatic logic [20:0] pick_index(logic [31:0] len, bit in_range);
        logic [31:0] top;
        if ($urandom_range(0, 5) == 0)
            return 21'($urandom);
        if (in_range)
        begin
            if (len == 0)
                return 21'($urandom);
            top = (len > 32'h001F_FFFF) ? 32'h001F_FFFF : len - 1;
            return ($urandom_range(0, 3) == 0) ? 21'(top) : 21'($urandom_range(0, top));
        end
        if (len > 32'h001F_FFFF)
            return 21'($urandom);
        return 21'(len + $urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] random_vaddr();
        logic [20:0] idx;
        logic [8:0]  off;
        off = 9'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                idx = pick_index(sb.p0_length, $urandom_range(0, 7) != 0);
                return {2'b00, idx, off};
            end
            4, 5:
            begin
                idx = pick_index(sb.p1_length, $urandom_range(0, 4) == 0);
                return {2'b01, idx, off};
            end
            6, 7, 8:
            begin
                idx = pick_index(sb.sys_length, $urandom_range(0, 7) != 0);
                return {2'b10, idx, off};
            end
            default: return {2'b11, 21'($urandom), off};
        endcase
    endfunction

    // follows the walk: mostly entry words while a walk is open, mostly requests otherwise
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it.mode = 1'($urandom);
        it.vaddr = $urandom;
        it.is_write = 1'($urandom);
        it.access_mode = 2'($urandom);
        it.read_data = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return it;
        if (sb.phase == PHASE_IDLE)
        begin
            it.mode = (pick < 14);
            if (!it.mode)
                it.vaddr = random_vaddr();
        end
        else if (pick < 18)
        begin
            it.mode = 1'b0;
            it.vaddr = random_vaddr();
        end
        else
        begin
            it.mode = 1'b1;
            it.read_data[31] = ($urandom_range(0, 7) != 0);
        end
        return it;
    endfunction

    initial
    begin : stimulus
        in_item_t it;
        int counted;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // mapping off out of reset, entry word while idle
        stall_mode = 1;
        send(request(32'hFFFF_FFFF, 1'b1, 2'd3));
        send(request(32'h0000_0000, 1'b0, 2'd0));
        send(entry(32'hFFFF_FFFF));
        wait_idle();

        write_reg(REG_P0_BASE, 32'h8000_0000);
        write_reg(REG_P0_LENGTH, 32'h003F_FFFF);
        write_reg(REG_P1_BASE, 32'h0000_1000);
        write_reg(REG_P1_LENGTH, 32'h001F_FFFF);
        write_reg(REG_SYS_BASE, 32'h0000_2000);
        write_reg(REG_SYS_LENGTH, 32'd16);
        write_reg(REG_MAP_ENABLE, 32'd1);
        @(negedge clk);
        cfg_wen <= 1'b0;

        // p0 through the system table, write back of modify bit
        send(request(32'h0000_0200, 1'b1, 2'd3));
        send(entry(pte(1'b1, 4'd4, 1'b0, 21'd5)));
        send(entry(pte(1'b1, 4'd4, 1'b0, 21'h1F_FFFF)));
        // s1, s0 length, s0 not valid
        send(request(32'hC000_0000, 1'b0, 2'd0));
        send(request(32'h8000_0000 + 20 * 512, 1'b0, 2'd0));
        send(request(32'h8000_0000 + 3 * 512 + 7, 1'b0, 2'd0));
        send(entry(pte(1'b0, 4'd4, 1'b0, 21'd1)));
        // p1 length, p1 entry read as physical with access fault
        send(request(32'h4000_0000, 1'b0, 2'd0));
        send(request(32'h7FFF_FFFF, 1'b0, 2'd2));
        send(entry(pte(1'b1, 4'd0, 1'b1, 21'd3)));
        // process entry outside the system table, system entry faults
        send(request(32'h0020_0000, 1'b0, 2'd0));
        send(request(32'h0000_0400, 1'b0, 2'd1));
        send(entry(pte(1'b1, 4'd0, 1'b0, 21'd0)));
        send(request(32'h0000_0400, 1'b0, 2'd1));
        send(entry(pte(1'b0, 4'd4, 1'b0, 21'd0)));
        // new request drops an open walk
        send(request(32'h0000_0600, 1'b0, 2'd0));
        send(request(32'h8000_0400, 1'b1, 2'd3));
        send(entry(pte(1'b1, 4'd15, 1'b0, 21'd7)));
        send(request(32'h8000_0400, 1'b1, 2'd0));
        send(entry(pte(1'b1, 4'd4, 1'b1, 21'd7)));
        // walk left open across the next register change
        send(request(32'h0000_0200, 1'b0, 2'd0));

        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            configure(ph);
            case (ph % 4)
                0:
                begin
                    gap_max = 0;
                    stall_mode = 0;
                end
                1:
                begin
                    gap_max = 3;
                    stall_mode = 1;
                end
                2:
                begin
                    gap_max = 12;
                    stall_mode = 2;
                end
                default:
                begin
                    gap_max = 0;
                    stall_mode = 1;
                end
            endcase
            if (ph == 3)
                hold_request = 1'b1;
            counted = 0;
            while (counted < 127)
            begin
                pace();
                it = random_item();
                if (!(it.mode && sb.phase == PHASE_IDLE))
                    counted++;
                present(it);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("tb_vax_page_table_walker: clean");
        else
            $display("tb_vax_page_table_walker: errors");
        $finish;
    end
endmodule

### sim.f
hw/rtl/vpt_pkg.sv
hw/rtl/vpt_queue.sv
hw/rtl/vpt_front.sv
hw/rtl/vpt_back.sv
hw/rtl/vax_page_table_walker.sv
tb/sv/tb_vax_page_table_walker.sv
